>>> hw/rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normalize pipeline
// Widths of the component, square-sum, root and quotient paths.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

	// Component width and the unit vector fraction bits (one is 2^UNIT_FRAC).
	localparam int COMP_W    = 32;
	localparam int UNIT_FRAC = 30;
	localparam int OUT_W     = 32;

	// Square sum, root and quotient widths.
	localparam int SUM_W  = 2 * COMP_W;
	localparam int ROOT_W = COMP_W;
	localparam int QUOT_W = UNIT_FRAC + 1;

	// Per-item side data that rides along with the square root pipeline.
	typedef struct packed {
		logic              td;
		logic              nx;
		logic              ny;
		logic              nz;
		logic [COMP_W-1:0] ax;
		logic [COMP_W-1:0] ay;
		logic [COMP_W-1:0] az;
	} side_t;

	// Per-item data that rides along with the divider pipeline.
	typedef struct packed {
		logic              td;
		logic [ROOT_W-1:0] mag;
	} tag_t;

endpackage

`default_nettype wire

>>> hw/rtl/vn_square.sv
// ----------------------------------------------------------------------------
// vn_square: absolute value, squaring and summation
// Three register stages: magnitudes, squares, square sum.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_square (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       ce,
	input  wire logic                       in_valid,
	input  wire logic                       three_d,
	input  wire logic [vn_pkg::COMP_W-1:0]  comp_x,
	input  wire logic [vn_pkg::COMP_W-1:0]  comp_y,
	input  wire logic [vn_pkg::COMP_W-1:0]  comp_z,
	output logic                            out_valid,
	output logic [vn_pkg::SUM_W-1:0]        sum,
	output vn_pkg::side_t                   side
);
	import vn_pkg::*;

	logic              valid_s1, valid_s2, valid_s3;
	side_t             side_s1, side_s2, side_s3;
	logic [SUM_W-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [SUM_W-1:0]  sum_s3;
	logic [COMP_W-1:0] zabs;

	// A 2D item takes z as zero.
	assign zabs = comp_z[COMP_W-1] ? (~comp_z + 1'b1) : comp_z;

	// Valid bits advance with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage data: magnitudes, then squares, then the exact sum.
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s1.td <= three_d;
			side_s1.nx <= comp_x[COMP_W-1];
			side_s1.ny <= comp_y[COMP_W-1];
			side_s1.nz <= three_d & comp_z[COMP_W-1];
			side_s1.ax <= comp_x[COMP_W-1] ? (~comp_x + 1'b1) : comp_x;
			side_s1.ay <= comp_y[COMP_W-1] ? (~comp_y + 1'b1) : comp_y;
			side_s1.az <= three_d ? zabs : '0;

			side_s2 <= side_s1;
			sqx_s2  <= SUM_W'(side_s1.ax) * SUM_W'(side_s1.ax);
			sqy_s2  <= SUM_W'(side_s1.ay) * SUM_W'(side_s1.ay);
			sqz_s2  <= SUM_W'(side_s1.az) * SUM_W'(side_s1.az);

			side_s3 <= side_s2;
			sum_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
		end
	end

	assign out_valid = valid_s3;
	assign sum       = sum_s3;
	assign side      = side_s3;

endmodule

`default_nettype wire

>>> hw/rtl/vn_isqrt.sv
// ----------------------------------------------------------------------------
// vn_isqrt: pipelined floor square root
// One result bit per register stage, ROOT_W stages in all.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      ce,
	input  wire logic                      in_valid,
	input  wire logic [vn_pkg::SUM_W-1:0]  num,
	input  wire vn_pkg::side_t             in_side,
	output logic                           out_valid,
	output logic [vn_pkg::ROOT_W-1:0]      root,
	output vn_pkg::side_t                  out_side
);
	import vn_pkg::*;

	logic [SUM_W-1:0] num_s  [0:ROOT_W];
	logic [SUM_W-1:0] res_s  [0:ROOT_W];
	side_t            side_s [0:ROOT_W];
	logic             valid_s[0:ROOT_W];

	assign num_s[0]   = num;
	assign res_s[0]   = '0;
	assign side_s[0]  = in_side;
	assign valid_s[0] = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
		logic [SUM_W-1:0] trial;

		// Trial subtraction of the current root plus this stage's bit.
		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (ce) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				side_s[k+1] <= side_s[k];
				if (num_s[k] >= trial) begin
					num_s[k+1] <= num_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					num_s[k+1] <= num_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign root      = res_s[ROOT_W][ROOT_W-1:0];
	assign out_side  = side_s[ROOT_W];

endmodule

`default_nettype wire

>>> hw/rtl/vn_divider.sv
// ----------------------------------------------------------------------------
// vn_divider: pipelined restoring divider for one unit component
// Computes (a * 2^UNIT_FRAC) / len, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      ce,
	input  wire logic                      in_valid,
	input  wire logic [vn_pkg::COMP_W-1:0] a,
	input  wire logic                      in_neg,
	input  wire logic [vn_pkg::ROOT_W-1:0] len,
	input  wire vn_pkg::tag_t              in_tag,
	output logic                           out_valid,
	output logic [vn_pkg::QUOT_W-1:0]      quot,
	output logic                           out_neg,
	output vn_pkg::tag_t                   out_tag
);
	import vn_pkg::*;

	// The quotient never reaches 2^QUOT_W, so the dividend bits above the
	// quotient range seed the remainder directly.
	logic [ROOT_W-1:0] rem_s  [0:QUOT_W];
	logic [QUOT_W-1:0] low_s  [0:QUOT_W];
	logic [QUOT_W-1:0] quot_s [0:QUOT_W];
	logic [ROOT_W-1:0] len_s  [0:QUOT_W];
	logic              neg_s  [0:QUOT_W];
	tag_t              tag_s  [0:QUOT_W];
	logic              valid_s[0:QUOT_W];

	assign rem_s[0]   = ROOT_W'(a[COMP_W-1:1]);
	assign low_s[0]   = {a[0], {(QUOT_W-1){1'b0}}};
	assign quot_s[0]  = '0;
	assign len_s[0]   = len;
	assign neg_s[0]   = in_neg;
	assign tag_s[0]   = in_tag;
	assign valid_s[0] = in_valid;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		logic [ROOT_W:0] shifted;
		logic            take;

		// Bring down the next dividend bit and compare with the divisor.
		assign shifted = {rem_s[k], low_s[k][QUOT_W-1]};
		assign take    = shifted >= {1'b0, len_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (ce) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1]  <= take ? ROOT_W'(shifted - {1'b0, len_s[k]})
				                    : shifted[ROOT_W-1:0];
				low_s[k+1]  <= low_s[k] << 1;
				quot_s[k+1] <= {quot_s[k][QUOT_W-2:0], take};
				len_s[k+1]  <= len_s[k];
				neg_s[k+1]  <= neg_s[k];
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_valid = valid_s[QUOT_W];
	assign quot      = quot_s[QUOT_W];
	assign out_neg   = neg_s[QUOT_W];
	assign out_tag   = tag_s[QUOT_W];

endmodule

`default_nettype wire

>>> hw/rtl/vector_normalize_top.sv
// Throughput: one vector per cycle while the output is not stalled; the square
// root and the three dividers are fully pipelined, one result bit per stage.
// A stall on the output holds the whole pipeline; nothing is dropped.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// vector_normalize_top: Euclidean length and unit vector of a 2D/3D vector
// Squares and sums the components, takes the floor root, then divides.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalize_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// comp_x [31:0], comp_y [63:32], comp_z [95:64]
	input  wire logic [95:0]  s_axis_tdata,
	// three_d [0]
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// magnitude [31:0], unit_x [63:32], unit_y [95:64], unit_z [127:96]
	output logic [127:0]      m_axis_tdata,
	// zero_error [0]
	output logic              m_axis_tuser
);
	import vn_pkg::*;

	logic              ce;
	logic              sq_valid, rt_valid;
	logic [SUM_W-1:0]  sq_sum;
	side_t             sq_side, rt_side;
	logic [ROOT_W-1:0] rt_root;
	tag_t              rt_tag;
	logic              dx_valid, dy_valid, dz_valid;
	logic [QUOT_W-1:0] qx, qy, qz;
	logic              nx, ny, nz;
	tag_t              tag_x, tag_y, tag_z;
	logic              zero;
	logic [OUT_W-1:0]  ux, uy, uz;

	// The pipeline advances when the output register is free or drained.
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	vn_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_axis_tvalid),
		.three_d   (s_axis_tuser),
		.comp_x    (s_axis_tdata[31:0]),
		.comp_y    (s_axis_tdata[63:32]),
		.comp_z    (s_axis_tdata[95:64]),
		.out_valid (sq_valid),
		.sum       (sq_sum),
		.side      (sq_side)
	);

	vn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (sq_valid),
		.num       (sq_sum),
		.in_side   (sq_side),
		.out_valid (rt_valid),
		.root      (rt_root),
		.out_side  (rt_side)
	);

	assign rt_tag.td  = rt_side.td;
	assign rt_tag.mag = rt_root;

	vn_divider u_div_x (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (rt_valid),
		.a (rt_side.ax), .in_neg (rt_side.nx), .len (rt_root), .in_tag (rt_tag),
		.out_valid (dx_valid), .quot (qx), .out_neg (nx), .out_tag (tag_x)
	);

	vn_divider u_div_y (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (rt_valid),
		.a (rt_side.ay), .in_neg (rt_side.ny), .len (rt_root), .in_tag (rt_tag),
		.out_valid (dy_valid), .quot (qy), .out_neg (ny), .out_tag (tag_y)
	);

	vn_divider u_div_z (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (rt_valid),
		.a (rt_side.az), .in_neg (rt_side.nz), .len (rt_root), .in_tag (rt_tag),
		.out_valid (dz_valid), .quot (qz), .out_neg (nz), .out_tag (tag_z)
	);

	// Clamp to one and apply the sign.
	function automatic logic [OUT_W-1:0] unit_of(input logic [QUOT_W-1:0] q,
	                                             input logic neg);
		logic [OUT_W-1:0] mag;
		mag = (q > QUOT_W'(1) << UNIT_FRAC) ? (OUT_W'(1) << UNIT_FRAC) : OUT_W'(q);
		return neg ? (~mag + 1'b1) : mag;
	endfunction

	assign zero = (tag_x.mag == '0);
	assign ux   = unit_of(qx, nx);
	assign uy   = unit_of(qy, ny);
	assign uz   = unit_of(qz, nz);

	// Output register; a zero vector gives all-zero fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			m_axis_tvalid <= dx_valid & dy_valid & dz_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tuser  <= zero;
			m_axis_tdata  <= zero ? '0 : {(tag_z.td ? uz : '0), uy, ux,
			                               OUT_W'(tag_y.mag)};
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/vn_checker.sv
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for vector_normalize_top
// Watches the result channel for stall and value consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [127:0] m_axis_tdata,
	input wire logic         m_axis_tuser
);

	// A stalled result transfer keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A zero vector shows all fields zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("zero vector with nonzero fields");

	// A nonzero vector has a nonzero length.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] != '0)
		else $error("zero length without error flag");

	// The unit x component stays within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[63:32]) <= 32'sh4000_0000 &&
		                  $signed(m_axis_tdata[63:32]) >= -32'sh4000_0000)
		else $error("unit x out of range");

endmodule

bind vector_normalize_top vn_checker u_vn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
